/* hw/rtl/fstt_pkg.sv */
// ----------------------------------------------------------------------------
// fstt_pkg
// Shared request and response types and a helper for the fault site tally
// table.
// ----------------------------------------------------------------------------
`default_nettype none

package fstt_pkg;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic        op;
        logic        is_access_violation;
        logic [63:0] fault_addr;
        logic [63:0] module_base;
        logic [31:0] thread_id;
        logic [4:0]  read_index;
    } fault_req_t;

    typedef struct packed {
        logic [4:0]  slot;
        logic [31:0] hit_count;
        logic        report;
        logic        new_site;
        logic        full_notice;
        logic [31:0] total_faults;
        logic [63:0] module_offset;
        logic [63:0] entry_address;
        logic [63:0] entry_module_base;
        logic [31:0] entry_thread;
        logic [5:0]  sites_used;
        logic        table_full;
    } site_rsp_t;

    // address relative to its module, zero when the base is unknown
    function automatic logic [63:0] offset_of(input logic [63:0] addr,
                                              input logic [63:0] base);
        return (base != 64'd0) ? (addr - base) : 64'd0;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/fstt_req_if.sv */
// ----------------------------------------------------------------------------
// fstt_req_if
// Valid/ready channel carrying fault record and site read requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface fstt_req_if;
    logic                   valid;
    logic                   ready;
    fstt_pkg::fault_req_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fstt_rsp_if.sv */
// ----------------------------------------------------------------------------
// fstt_rsp_if
// Valid/ready channel carrying site tally results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fstt_rsp_if;
    logic                   valid;
    logic                   ready;
    fstt_pkg::site_rsp_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fstt_ram.sv */
// ----------------------------------------------------------------------------
// fstt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fstt_engine.sv */
// ----------------------------------------------------------------------------
// fstt_engine
// Request sequencer: scans the site memory for the faulting address, then
// reads, modifies and writes back the matching or new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fstt_engine #(
    parameter int SITES        = 32,
    parameter int REPORT_EVERY = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    fstt_req_if.sink            req,
    output logic                res_valid,
    input  wire logic           res_ready,
    output fstt_pkg::site_rsp_t res_data
);

    localparam int ADDR_W = $clog2(SITES);
    localparam int CNT_W  = $clog2(SITES + 1);
    localparam int EXT_W  = (CNT_W > 6) ? CNT_W : 6;
    localparam int PH_W   = $clog2(REPORT_EVERY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_RDATA  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    typedef struct packed {
        logic [63:0]     address;
        logic [63:0]     module_base;
        logic [31:0]     count;
        logic [31:0]     origin_thread;
        logic [PH_W-1:0] phase;
    } entry_t;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [ADDR_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                hit_reg, hit_next;
    logic [ADDR_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic                full_reg, full_next;
    logic [31:0]         total_reg, total_next;

    logic [63:0]         item_addr_reg;
    logic [63:0]         item_base_reg;
    logic [31:0]         item_tid_reg;
    logic [4:0]          item_ridx_reg;
    logic                item_rok_reg;
    fstt_pkg::site_rsp_t res_reg, res_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    entry_t              ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    entry_t              ram_rdata;

    logic                accept;
    logic                ridx_ok;
    logic [EXT_W-1:0]    ridx_ext;
    logic                match;
    logic                rose;
    logic [31:0]         count_inc;
    logic [PH_W-1:0]     phase_inc;
    logic                room;

    fstt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SITES)
    ) u_site_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign res_valid = (state_reg == S_EMIT);
    assign res_data  = res_reg;

    assign ridx_ext  = EXT_W'(req.data.read_index);
    assign ridx_ok   = ridx_ext < EXT_W'(used_reg);
    assign match     = cmp_vld_reg && (ram_rdata.address == item_addr_reg);
    assign rose      = (ram_rdata.count != 32'hFFFF_FFFF);
    assign count_inc = ram_rdata.count + 32'd1;
    assign phase_inc = (ram_rdata.phase == PH_W'(REPORT_EVERY - 1)) ?
                       '0 : (ram_rdata.phase + PH_W'(1));
    assign room      = used_reg < CNT_W'(SITES);

    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        used_next    = used_reg;
        full_next    = full_reg;
        total_next   = total_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = hit_idx_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = scan_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.data.op == fstt_pkg::OP_READ)
                    begin
                        ram_re     = ridx_ok;
                        ram_raddr  = ridx_ext[ADDR_W-1:0];
                        state_next = S_RDATA;
                    end
                    else if (req.data.is_access_violation)
                    begin
                        if (total_reg != 32'hFFFF_FFFF)
                        begin
                            total_next = total_reg + 32'd1;
                        end
                        scan_next    = '0;
                        cmp_vld_next = 1'b0;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    state_next   = S_UPDATE;
                end
                else if (scan_reg < used_reg)
                begin
                    ram_re       = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[ADDR_W-1:0];
                    scan_next    = scan_reg + CNT_W'(1);
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                res_next               = '0;
                res_next.total_faults  = total_reg;
                res_next.module_offset = fstt_pkg::offset_of(item_addr_reg, item_base_reg);
                if (hit_reg)
                begin
                    ram_we             = 1'b1;
                    ram_waddr          = hit_idx_reg;
                    ram_wdata          = ram_rdata;
                    if (rose)
                    begin
                        ram_wdata.count = count_inc;
                        ram_wdata.phase = phase_inc;
                    end
                    res_next.slot      = 5'(hit_idx_reg);
                    res_next.hit_count = rose ? count_inc : ram_rdata.count;
                    res_next.report    = rose && (phase_inc == '0);
                end
                else if (room)
                begin
                    ram_we                  = 1'b1;
                    ram_waddr               = used_reg[ADDR_W-1:0];
                    ram_wdata.address       = item_addr_reg;
                    ram_wdata.module_base   = item_base_reg;
                    ram_wdata.count         = 32'd1;
                    ram_wdata.origin_thread = item_tid_reg;
                    ram_wdata.phase         = PH_W'(1);
                    used_next               = used_reg + CNT_W'(1);
                    res_next.slot           = 5'(used_reg);
                    res_next.hit_count      = 32'd1;
                    res_next.report         = 1'b1;
                    res_next.new_site       = 1'b1;
                end
                else
                begin
                    res_next.full_notice = !full_reg;
                    full_next            = 1'b1;
                end
                res_next.sites_used = 6'(used_next);
                res_next.table_full = full_next;
                state_next          = S_EMIT;
            end
            S_RDATA:
            begin
                res_next              = '0;
                res_next.slot         = item_ridx_reg;
                res_next.total_faults = total_reg;
                if (item_rok_reg)
                begin
                    res_next.hit_count         = ram_rdata.count;
                    res_next.module_offset     =
                        fstt_pkg::offset_of(ram_rdata.address, ram_rdata.module_base);
                    res_next.entry_address     = ram_rdata.address;
                    res_next.entry_module_base = ram_rdata.module_base;
                    res_next.entry_thread      = ram_rdata.origin_thread;
                end
                res_next.sites_used = 6'(used_reg);
                res_next.table_full = full_reg;
                state_next          = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            scan_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            used_reg    <= '0;
            full_reg    <= 1'b0;
            total_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            used_reg    <= used_next;
            full_reg    <= full_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        res_reg     <= res_next;
        if (accept)
        begin
            item_addr_reg <= req.data.fault_addr;
            item_base_reg <= req.data.module_base;
            item_tid_reg  <= req.data.thread_id;
            item_ridx_reg <= req.data.read_index;
            item_rok_reg  <= ridx_ok;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fault_site_tally_table_core.sv */
// ----------------------------------------------------------------------------
// fault_site_tally_table_core
// Tallies access faults by faulting address in a table of sites held in
// one on-chip RAM, and answers site read requests.
// ----------------------------------------------------------------------------
// usage
//   fault_req carries one request: a fault record (op 0) or a site read
//   (op 1). a record that is not an access violation is taken and dropped
//   with no response. every other request gives one response on site_rsp.
//   a record scans the filled slots one per cycle through the site RAM
//   read port, then writes the matched or new entry back. a read request
//   reads its slot through the same port and is answered from that data.
//   one request is in flight at a time; the next is taken on the cycle
//   after the previous response enters the output register, so a new
//   request is only taken once the previous one is through.
//   while site_rsp is stalled the output register holds its response and
//   one further response can wait in the sequencer.
//   reset empties the table, clears the full flag and the fault total;
//   the RAM contents need no clearing as only filled slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_site_tally_table_core #(
    parameter int SITES        = 32,
    parameter int REPORT_EVERY = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fstt_req_if.sink   fault_req,
    fstt_rsp_if.source site_rsp
);

    logic                res_valid;
    logic                res_ready;
    fstt_pkg::site_rsp_t res_data;

    logic                out_valid_reg, out_valid_next;
    fstt_pkg::site_rsp_t out_data_reg;

    fstt_engine #(
        .SITES        (SITES),
        .REPORT_EVERY (REPORT_EVERY)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (fault_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // output stage frees when empty or when its response is taken
    assign res_ready = !out_valid_reg || site_rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign site_rsp.valid = out_valid_reg;
    assign site_rsp.data  = out_data_reg;

endmodule

`default_nettype wire
